### hw/rtl/hacs_pkg.sv
// Package for the hi-res artifact color scanout block.
// Holds shared constants, state and command types, and the palette function.
// No dependencies.
package hacs_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int ROW_COUNT = 192;
  localparam int COLUMNS   = 40;
  localparam int PIXELS    = 7;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [23:0] COLOR_BLACK  = 24'h000000;
  localparam logic [23:0] COLOR_PURPLE = 24'hD53EF9;
  localparam logic [23:0] COLOR_BLUE   = 24'h458FF7;
  localparam logic [23:0] COLOR_ORANGE = 24'hD7762C;
  localparam logic [23:0] COLOR_GREEN  = 24'h64D440;
  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_LEFT,
    ST_RD_CUR,
    ST_RD_RIGHT,
    ST_RD_LAST,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_LEFT,
    SEL_CUR,
    SEL_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    clear_we;
    rd_sel_t rd_sel;
    logic    cap_left;
    logic    cap_cur;
    logic    cap_right;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic render_ok;
    logic clear_last;
    logic out_free;
    logic bit_last;
  } status_t;

  function automatic logic [23:0] artifact_color(logic [2:0] nbhd, logic parity, logic pal);
    logic [1:0] c;
    if (nbhd[1]) begin
      c = (nbhd[0] | nbhd[2]) ? 2'd3 : (parity ? 2'd2 : 2'd1);
    end else begin
      c = (nbhd[0] & nbhd[2]) ? (parity ? 2'd1 : 2'd2) : 2'd0;
    end
    unique case (c)
      2'd0: artifact_color = COLOR_BLACK;
      2'd1: artifact_color = pal ? COLOR_BLUE : COLOR_PURPLE;
      2'd2: artifact_color = pal ? COLOR_ORANGE : COLOR_GREEN;
      default: artifact_color = COLOR_WHITE;
    endcase
  endfunction

endpackage

### hw/rtl/hacs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/hacs_ctrl.sv
// Controller state machine: clear sweep, item accept, neighbor reads, pixel emit.
// Depends on hacs_pkg.
module hacs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  hacs_pkg::status_t stat,
  output hacs_pkg::cmd_t    cmd
);

  hacs_pkg::state_t state, state_next;
  logic accept;

  assign accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hacs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hacs_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = hacs_pkg::ST_IDLE;
      end
      hacs_pkg::ST_IDLE: begin
        if (accept && stat.render_ok) state_next = hacs_pkg::ST_RD_LEFT;
      end
      hacs_pkg::ST_RD_LEFT:  state_next = hacs_pkg::ST_RD_CUR;
      hacs_pkg::ST_RD_CUR:   state_next = hacs_pkg::ST_RD_RIGHT;
      hacs_pkg::ST_RD_RIGHT: state_next = hacs_pkg::ST_RD_LAST;
      hacs_pkg::ST_RD_LAST:  state_next = hacs_pkg::ST_EMIT;
      hacs_pkg::ST_EMIT: begin
        if (stat.out_free && stat.bit_last) state_next = hacs_pkg::ST_IDLE;
      end
      default: state_next = hacs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd.accept    = accept;
    cmd.clear_we  = 1'b0;
    cmd.rd_sel    = hacs_pkg::SEL_CUR;
    cmd.cap_left  = 1'b0;
    cmd.cap_cur   = 1'b0;
    cmd.cap_right = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state)
      hacs_pkg::ST_CLEAR:    cmd.clear_we = 1'b1;
      hacs_pkg::ST_IDLE:     s_tready = 1'b1;
      hacs_pkg::ST_RD_LEFT:  cmd.rd_sel = hacs_pkg::SEL_LEFT;
      hacs_pkg::ST_RD_CUR: begin
        cmd.rd_sel   = hacs_pkg::SEL_CUR;
        cmd.cap_left = 1'b1;
      end
      hacs_pkg::ST_RD_RIGHT: begin
        cmd.rd_sel  = hacs_pkg::SEL_RIGHT;
        cmd.cap_cur = 1'b1;
      end
      hacs_pkg::ST_RD_LAST:  cmd.cap_right = 1'b1;
      hacs_pkg::ST_EMIT:     cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

### hw/rtl/hacs_datapath.sv
// Datapath: item registers, interleaved address, screen RAM, neighbor bytes,
// pixel counter and output register. Depends on hacs_pkg and hacs_ram.
module hacs_datapath #(
  parameter int MEM_BYTES = hacs_pkg::MEM_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hacs_pkg::cmd_t                      cmd,
  output hacs_pkg::status_t                   stat,
  input  logic [hacs_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hacs_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  localparam int AW = $clog2(MEM_BYTES);

  logic [12:0] in_waddr;
  logic [7:0]  in_wbyte;
  logic [7:0]  in_row;
  logic [5:0]  in_col;

  assign in_waddr = s_tdata[12:0];
  assign in_wbyte = s_tdata[20:13];
  assign in_row   = s_tdata[28:21];
  assign in_col   = s_tdata[34:29];

  logic [7:0] row;
  logic [5:0] col;
  logic [7:0] left_byte, cur_byte, right_byte;
  logic [2:0] bit_idx;
  logic [AW-1:0] clear_addr;

  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          ram_we;

  logic [5:0]  rd_col;
  logic [7:0]  base, lo;
  logic [12:0] full_addr;

  always_comb begin
    unique case (cmd.rd_sel)
      hacs_pkg::SEL_LEFT:  rd_col = col - 6'd1;
      hacs_pkg::SEL_RIGHT: rd_col = col + 6'd1;
      default:             rd_col = col;
    endcase
    base      = {1'b0, row[7:6], 5'b0} + {3'b0, row[7:6], 3'b0};
    lo        = base + {2'b0, rd_col};
    full_addr = {row[2:0], row[5:3], 7'b0} | {5'b0, lo};
  end

  assign ram_raddr = full_addr[AW-1:0];
  assign ram_we    = cmd.clear_we | (cmd.accept & (s_tuser == hacs_pkg::OP_WRITE));
  assign ram_waddr = cmd.clear_we ? clear_addr : in_waddr[AW-1:0];
  assign ram_wdata = cmd.clear_we ? 8'd0 : in_wbyte;

  hacs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_we) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row <= in_row;
      col <= in_col;
    end
    if (cmd.cap_left) begin
      left_byte <= (col == 6'd0) ? 8'd0 : ram_rdata;
    end
    if (cmd.cap_cur) begin
      cur_byte <= ram_rdata;
    end
    if (cmd.cap_right) begin
      right_byte <= (col == 6'(hacs_pkg::COLUMNS - 1)) ? 8'd0 : ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx <= '0;
    end else if (cmd.accept) begin
      bit_idx <= '0;
    end else if (cmd.emit) begin
      bit_idx <= bit_idx + 3'd1;
    end
  end

  logic [20:0] w;
  logic [2:0]  nbhd;
  logic [23:0] color;
  logic [8:0]  px;

  assign w     = {right_byte[6:0], cur_byte[6:0], left_byte[6:0]};
  assign nbhd  = w[5'(bit_idx) + 5'd6 +: 3];
  assign color = hacs_pkg::artifact_color(nbhd, bit_idx[0] ^ col[0], cur_byte[7]);
  assign px    = {col, 3'b0} - {3'b0, col} + {6'b0, bit_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'b0, px, color};
      m_tlast <= (bit_idx == 3'(hacs_pkg::PIXELS - 1));
    end
  end

  assign stat.render_ok  = (s_tuser == hacs_pkg::OP_RENDER)
                         && (in_row < 8'(hacs_pkg::ROW_COUNT))
                         && (in_col < 6'(hacs_pkg::COLUMNS));
  assign stat.clear_last = (clear_addr == AW'(MEM_BYTES - 1));
  assign stat.out_free   = ~m_tvalid | m_tready;
  assign stat.bit_last   = (bit_idx == 3'(hacs_pkg::PIXELS - 1));

endmodule

### hw/rtl/hires_artifact_color_scanout_top.sv
// Render item: accepted in ST_IDLE; ST_RD_LEFT, ST_RD_CUR and ST_RD_RIGHT make 3 reads on one
// RAM port, ST_RD_LAST captures the right byte and ST_EMIT puts 7 pixels through the output
// register, one pixel per cycle while m_tready does not stall it. Write items and ignored renders
// are accepted in ST_IDLE. Reset starts a clearing pass over the screen RAM; s_tready stays low.
// Top level of the hi-res artifact color scanout. Depends on hacs_pkg, hacs_ctrl,
// hacs_datapath.
module hires_artifact_color_scanout_top #(
  parameter int MEM_BYTES = hacs_pkg::MEM_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // write_address[12:0], write_byte[20:13], row_number[28:21], byte_column[34:29]
  input  logic [hacs_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_color[23:0], pixel_x[32:24]
  output logic [hacs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  hacs_pkg::cmd_t    cmd;
  hacs_pkg::status_t stat;

  hacs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hacs_datapath #(.MEM_BYTES(MEM_BYTES)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### hw/rtl/hacs_checker.sv
// Port-level checker for the hi-res artifact color scanout, bound to the top.
// Depends on hacs_pkg and hires_artifact_color_scanout_top.
module hacs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [hacs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("input ready during clearing pass");

  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("input ready while a render run is unfinished");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("render run ended before its last pixel");

  a_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32:24] < 9'd280) && (m_tdata[39:33] == 7'd0))
    else $error("pixel position out of range");

endmodule

bind hires_artifact_color_scanout_top hacs_checker u_hacs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
